// ----- hdl/elm_pkg.sv -----
// Shared types and constants for the look-at view matrix unit.
package elm_pkg;

	localparam int unsigned ANG_FULL    = 23040;
	localparam int unsigned ANG_QUARTER = 5760;
	localparam int unsigned ANG_HALFQ   = 2880;
	// floor(n/5760) == (n*RECIP_M) >> RECIP_S for n below 2^28
	localparam int unsigned RECIP_S     = 38;
	localparam logic [25:0] RECIP_M     = 26'd47721859;

	typedef struct packed {
		logic signed [15:0] pitch_angle;
		logic signed [15:0] yaw_angle;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} pose_t;

	typedef struct packed {
		logic signed [15:0] m00;
		logic signed [15:0] m01;
		logic signed [15:0] m02;
		logic signed [15:0] m10;
		logic signed [15:0] m11;
		logic signed [15:0] m12;
		logic signed [15:0] m20;
		logic signed [15:0] m21;
		logic signed [15:0] m22;
		logic signed [31:0] tx;
		logic signed [31:0] ty;
		logic signed [31:0] tz;
	} view_t;

endpackage

// ----- hdl/elm_pose_if.sv -----
// Handshake channel carrying one camera pose item.
interface elm_pose_if;
	logic             valid;
	logic             ready;
	elm_pkg::pose_t   data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/elm_view_if.sv -----
// Handshake channel carrying one view matrix item.
interface elm_view_if;
	logic             valid;
	logic             ready;
	elm_pkg::view_t   data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/euler_look_at_view_matrix_unit.sv -----
// Yaw/pitch look-at view matrix unit: nine-stage pipeline, top level.
//
//  channel | dir | payload                     | handshake
//  pose    | in  | pitch, yaw, pos x/y/z       | valid/ready
//  view    | out | m00..m22 Q2.14, tx/ty/tz    | valid/ready
//
// One item per cycle sustained while view.ready is high; nine register stages, and
// view.valid rises when the item reaches the last (saturate) stage.
// Stages: angle wrap, index scaling, reciprocal multiply, sine ROM read,
// trig products, vector build, position products, sums, saturate.
// Reset clears only the stage valid bits; the sine ROM is constant.
// Each stage holds when its successor is full and stalled, so bubbles collapse.
module euler_look_at_view_matrix_unit #(
	parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	elm_pose_if.sink    pose,
	elm_view_if.source  view
);

	localparam int unsigned IW = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int unsigned NW = $clog2(5759 * SINE_TABLE_DEPTH + 2881);
	localparam int unsigned PW = NW + 26;
	localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

	function automatic logic [30:0] sin_entry(input longint unsigned k);
		longint unsigned x, x2, t;
		longint          s;
		x  = (PI_HALF_Q30 * k + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
		x2 = (x * x) >> 30;
		t  = x;
		s  = longint'(x);
		t = ((t * x2) >> 30) / 6;   s = s - longint'(t);
		t = ((t * x2) >> 30) / 20;  s = s + longint'(t);
		t = ((t * x2) >> 30) / 42;  s = s - longint'(t);
		t = ((t * x2) >> 30) / 72;  s = s + longint'(t);
		t = ((t * x2) >> 30) / 110; s = s - longint'(t);
		t = ((t * x2) >> 30) / 156; s = s + longint'(t);
		t = ((t * x2) >> 30) / 210; s = s - longint'(t);
		t = ((t * x2) >> 30) / 272; s = s + longint'(t);
		t = ((t * x2) >> 30) / 342; s = s - longint'(t);
		if (s < 0) s = 0;
		if (s > 64'sd1073741824) s = 64'sd1073741824;
		return 31'(s);
	endfunction

	// round to nearest, halves away from zero
	function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
		input int unsigned sh);
		logic [63:0] mag;
		mag = v[63] ? 64'(-v) : 64'(v);
		mag = (mag + (64'd1 << (sh - 1))) >> sh;
		return v[63] ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647)  return 32'sh7fffffff;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return 32'(x);
	endfunction

	function automatic logic [14:0] wrap(input logic signed [15:0] a);
		logic [17:0] w;
		w = 18'($signed(a)) + 18'(2 * elm_pkg::ANG_FULL);
		if (w >= 18'(3 * elm_pkg::ANG_FULL))      w = w - 18'(3 * elm_pkg::ANG_FULL);
		else if (w >= 18'(2 * elm_pkg::ANG_FULL)) w = w - 18'(2 * elm_pkg::ANG_FULL);
		else if (w >= 18'(elm_pkg::ANG_FULL))     w = w - 18'(elm_pkg::ANG_FULL);
		return w[14:0];
	endfunction

	function automatic logic [1:0] quad(input logic [14:0] r);
		priority if (r >= 15'(3 * elm_pkg::ANG_QUARTER)) return 2'd3;
		else if (r >= 15'(2 * elm_pkg::ANG_QUARTER))     return 2'd2;
		else if (r >= 15'(elm_pkg::ANG_QUARTER))         return 2'd1;
		else                                             return 2'd0;
	endfunction

	function automatic logic [NW-1:0] scale(input logic [14:0] r, input logic [1:0] q);
		logic [14:0] o;
		o = r - 15'(q) * 15'(elm_pkg::ANG_QUARTER);
		return NW'(o[12:0]) * NW'(SINE_TABLE_DEPTH) + NW'(elm_pkg::ANG_HALFQ);
	endfunction

	// sine ROMs, one per angle, two read ports each
	logic [30:0] tab_p [SINE_TABLE_DEPTH + 1];
	logic [30:0] tab_y [SINE_TABLE_DEPTH + 1];
	for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_tab
		assign tab_p[g] = sin_entry(longint'(g));
		assign tab_y[g] = sin_entry(longint'(g));
	end

	logic [9:1] v;
	logic [9:1] en;

	always_comb begin
		en[9] = !v[9] || view.ready;
		for (int k = 8; k >= 1; k--) en[k] = !v[k] || en[k+1];
	end
	assign pose.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (en[1]) v[1] <= pose.valid;
			for (int k = 2; k <= 9; k++) if (en[k]) v[k] <= v[k-1];
		end
	end

	// position travels to stage 6
	logic signed [31:0] px_s1, py_s1, pz_s1, px_s2, py_s2, pz_s2, px_s3, py_s3, pz_s3;
	logic signed [31:0] px_s4, py_s4, pz_s4, px_s5, py_s5, pz_s5, px_s6, py_s6, pz_s6;
	logic [14:0]        rp_s1, ry_s1;
	logic [1:0]         qp_s2, qy_s2, qp_s3, qy_s3, qp_s4, qy_s4;
	logic [NW-1:0]      np_s2, ny_s2;
	logic [IW-1:0]      ip_s3, iy_s3;
	logic [30:0]        plo_s4, phi_s4, ylo_s4, yhi_s4;
	logic signed [31:0] sp, cp, sy, cy;
	logic signed [31:0] sp_s5, cp_s5, sy_s5, cy_s5;
	logic signed [63:0] cycp_s5, sycp_s5, cysp_s5, sysp_s5;
	logic signed [31:0] f0_s6, f1_s6, f2_s6, r0_s6, r2_s6, u0_s6, u1_s6, u2_s6;
	logic signed [63:0] pr0_s7, pr2_s7, pu0_s7, pu1_s7, pu2_s7, pf0_s7, pf1_s7, pf2_s7;
	logic signed [63:0] tx_s8, ty_s8, tz_s8;
	logic [15:0]        m_s7 [9];
	logic [15:0]        m_s8 [9];
	logic [PW-1:0]      prod_p, prod_y;
	elm_pkg::view_t     out_s9;

	assign prod_p = PW'(np_s2) * PW'(elm_pkg::RECIP_M);
	assign prod_y = PW'(ny_s2) * PW'(elm_pkg::RECIP_M);

	always_comb begin
		unique case (qp_s4)
			2'd0: begin sp = $signed({1'b0, plo_s4}); cp = $signed({1'b0, phi_s4}); end
			2'd1: begin sp = $signed({1'b0, phi_s4}); cp = -$signed({1'b0, plo_s4}); end
			2'd2: begin sp = -$signed({1'b0, plo_s4}); cp = -$signed({1'b0, phi_s4}); end
			default: begin sp = -$signed({1'b0, phi_s4}); cp = $signed({1'b0, plo_s4}); end
		endcase
		unique case (qy_s4)
			2'd0: begin sy = $signed({1'b0, ylo_s4}); cy = $signed({1'b0, yhi_s4}); end
			2'd1: begin sy = $signed({1'b0, yhi_s4}); cy = -$signed({1'b0, ylo_s4}); end
			2'd2: begin sy = -$signed({1'b0, ylo_s4}); cy = -$signed({1'b0, yhi_s4}); end
			default: begin sy = -$signed({1'b0, yhi_s4}); cy = $signed({1'b0, ylo_s4}); end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			rp_s1 <= wrap(pose.data.pitch_angle);
			ry_s1 <= wrap(pose.data.yaw_angle);
			px_s1 <= pose.data.pos_x;
			py_s1 <= pose.data.pos_y;
			pz_s1 <= pose.data.pos_z;
		end
		if (en[2]) begin
			qp_s2 <= quad(rp_s1);
			qy_s2 <= quad(ry_s1);
			np_s2 <= scale(rp_s1, quad(rp_s1));
			ny_s2 <= scale(ry_s1, quad(ry_s1));
			px_s2 <= px_s1; py_s2 <= py_s1; pz_s2 <= pz_s1;
		end
		if (en[3]) begin
			qp_s3 <= qp_s2;
			qy_s3 <= qy_s2;
			ip_s3 <= prod_p[elm_pkg::RECIP_S +: IW];
			iy_s3 <= prod_y[elm_pkg::RECIP_S +: IW];
			px_s3 <= px_s2; py_s3 <= py_s2; pz_s3 <= pz_s2;
		end
		if (en[4]) begin
			qp_s4  <= qp_s3;
			qy_s4  <= qy_s3;
			plo_s4 <= tab_p[ip_s3];
			phi_s4 <= tab_p[IW'(SINE_TABLE_DEPTH) - ip_s3];
			ylo_s4 <= tab_y[iy_s3];
			yhi_s4 <= tab_y[IW'(SINE_TABLE_DEPTH) - iy_s3];
			px_s4 <= px_s3; py_s4 <= py_s3; pz_s4 <= pz_s3;
		end
		if (en[5]) begin
			sp_s5 <= sp; cp_s5 <= cp; sy_s5 <= sy; cy_s5 <= cy;
			cycp_s5 <= cy * cp;
			sycp_s5 <= sy * cp;
			cysp_s5 <= cy * sp;
			sysp_s5 <= sy * sp;
			px_s5 <= px_s4; py_s5 <= py_s4; pz_s5 <= pz_s4;
		end
		if (en[6]) begin
			f0_s6 <= 32'(rnd(cycp_s5, 30));
			f1_s6 <= sp_s5;
			f2_s6 <= 32'(rnd(sycp_s5, 30));
			r0_s6 <= cp_s5[31] ? sy_s5 : -sy_s5;
			r2_s6 <= cp_s5[31] ? -cy_s5 : cy_s5;
			u0_s6 <= cp_s5[31] ? 32'(rnd(cysp_s5, 30)) : -32'(rnd(cysp_s5, 30));
			u1_s6 <= cp_s5[31] ? -cp_s5 : cp_s5;
			u2_s6 <= cp_s5[31] ? 32'(rnd(sysp_s5, 30)) : -32'(rnd(sysp_s5, 30));
			px_s6 <= px_s5; py_s6 <= py_s5; pz_s6 <= pz_s5;
		end
		if (en[7]) begin
			pr0_s7 <= r0_s6 * px_s6;
			pr2_s7 <= r2_s6 * pz_s6;
			pu0_s7 <= u0_s6 * px_s6;
			pu1_s7 <= u1_s6 * py_s6;
			pu2_s7 <= u2_s6 * pz_s6;
			pf0_s7 <= f0_s6 * px_s6;
			pf1_s7 <= f1_s6 * py_s6;
			pf2_s7 <= f2_s6 * pz_s6;
			m_s7[0] <= 16'(rnd(-64'(r0_s6), 16));
			m_s7[1] <= 16'd0;
			m_s7[2] <= 16'(rnd(-64'(r2_s6), 16));
			m_s7[3] <= 16'(rnd(-64'(u0_s6), 16));
			m_s7[4] <= 16'(rnd(-64'(u1_s6), 16));
			m_s7[5] <= 16'(rnd(-64'(u2_s6), 16));
			m_s7[6] <= 16'(rnd(-64'(f0_s6), 16));
			m_s7[7] <= 16'(rnd(-64'(f1_s6), 16));
			m_s7[8] <= 16'(rnd(-64'(f2_s6), 16));
		end
		if (en[8]) begin
			tx_s8 <= rnd(pr0_s7 + pr2_s7, 30);
			ty_s8 <= rnd(pu0_s7 + pu1_s7 + pu2_s7, 30);
			tz_s8 <= rnd(pf0_s7 + pf1_s7 + pf2_s7, 30);
			m_s8  <= m_s7;
		end
		if (en[9]) begin
			out_s9.m00 <= m_s8[0]; out_s9.m01 <= m_s8[1]; out_s9.m02 <= m_s8[2];
			out_s9.m10 <= m_s8[3]; out_s9.m11 <= m_s8[4]; out_s9.m12 <= m_s8[5];
			out_s9.m20 <= m_s8[6]; out_s9.m21 <= m_s8[7]; out_s9.m22 <= m_s8[8];
			out_s9.tx <= sat32(tx_s8);
			out_s9.ty <= sat32(ty_s8);
			out_s9.tz <= sat32(tz_s8);
		end
	end

	assign view.valid = v[9];
	assign view.data  = out_s9;

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!v[9] |-> pose.ready) else $error("input blocked with empty output stage");
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(&v) && !view.ready |-> !pose.ready) else $error("item taken into full pipeline");
	a_rot_range: assert property (@(posedge clk) disable iff (!arst_n)
		view.valid |-> view.data.m11 >= -16'sd16384 && view.data.m11 <= 16'sd16384
		&& view.data.m21 >= -16'sd16384 && view.data.m21 <= 16'sd16384)
		else $error("rotation entry out of range");

endmodule
